FILE: rtl/core/mvses_pkg.sv
// ----------------------------------------------------------------------------
// mvses_pkg
// Shared types and constants for the sine voice bank.
// ----------------------------------------------------------------------------
`default_nettype none

package mvses_pkg;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_NOTE_ON = 2'd1;
    localparam logic [1:0] OP_NOTE_OFF = 2'd2;

    localparam logic [1:0] MODE_FULL = 2'd0;
    localparam logic [1:0] MODE_ATTACK = 2'd1;
    localparam logic [1:0] MODE_DECAY = 2'd2;
    localparam logic [1:0] MODE_WAIT = 2'd3;

    localparam logic [1:0] REG_ATTACK_STEP = 2'd0;
    localparam logic [1:0] REG_DECAY_STEP = 2'd1;
    localparam logic [1:0] REG_OUTPUT_GAIN = 2'd2;

    localparam logic [23:0] LEVEL_ONE = 24'd4194304;
    localparam logic [31:0] RESET_INCREMENT = 32'd42852281;

    // Top-octave increments, MIDI keys 120..131.
    function automatic logic [31:0] top_octave_inc(input logic [3:0] note);
        logic [31:0] r;
        begin
            case (note)
                4'd0: r = 32'd815363808;
                4'd1: r = 32'd863847848;
                4'd2: r = 32'd915214973;
                4'd3: r = 32'd969636395;
                4'd4: r = 32'd1027293849;
                4'd5: r = 32'd1088379776;
                4'd6: r = 32'd1153098409;
                4'd7: r = 32'd1221664982;
                4'd8: r = 32'd1294309338;
                4'd9: r = 32'd1371273010;
                4'd10: r = 32'd1452813111;
                4'd11: r = 32'd1539202338;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

    // Increment for a key: table by note, shifted by octave.
    // Octave is key*43 >> 9, exact for keys 0..127.
    function automatic logic [31:0] key_increment(input logic [6:0] key);
        logic [12:0] k43;
        logic [3:0] oct;
        logic [3:0] note;
        logic [3:0] sh;
        begin
            k43 = 13'(key) * 13'd43;
            oct = 4'(k43 >> 9);
            note = 4'(key - 7'(oct) * 7'd12);
            sh = 4'd10 - oct;
            return top_octave_inc(note) >> sh;
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/multi_voice_sine_envelope_synth.sv
// ----------------------------------------------------------------------------
// multi_voice_sine_envelope_synth
// Bank of sine voices with linear attack/decay envelopes and a saturated mix.
// ----------------------------------------------------------------------------
// Note-on/off transactions: rate multiply and scale in S_RATE, write in S_NOTE.
// Tick: each voice steps through S_LOAD, S_T2, S_H1, S_H2, S_H3, S_M, S_G,
// S_L and S_ACC, then S_DONE registers the mix; one shared 32x32 multiplier.
// Throughput is set by the single multiplier doing 7 products per voice; a
// finished mix waits in S_DONE while the previous sample is still unaccepted.
// Reset: async active low; all voices full level at 440 Hz, phase zero.
`default_nettype none

module multi_voice_sine_envelope_synth #(
    parameter int VOICES = 8,
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  op,
    input  wire logic [3:0]  channel,
    input  wire logic [6:0]  key,
    input  wire logic [6:0]  velocity,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic signed [15:0] mixed_sample,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [22:0] cfg_data
);
    import mvses_pkg::*;

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int PW = SINE_TABLE_BITS - 2;

    typedef enum logic [3:0] {
        S_IDLE, S_RATE, S_NOTE, S_LOAD, S_T2, S_H1, S_H2, S_H3, S_M,
        S_G, S_L, S_ACC, S_DONE
    } state_t;

    state_t state_reg;

    logic [22:0] attack_step_reg, decay_step_reg;
    logic [15:0] output_gain_reg;

    logic [31:0] phase_mem [VOICES];
    logic [31:0] inc_mem [VOICES];
    logic [23:0] level_mem [VOICES];
    logic [1:0]  mode_mem [VOICES];
    logic        fin_mem [VOICES];
    logic [23:0] rate_mem [VOICES];

    logic [1:0]  op_reg;
    logic [3:0]  ch_reg;
    logic [6:0]  key_reg;
    logic [6:0]  vel_reg;
    logic [VW-1:0] v_reg;

    // Working registers of the shared datapath.
    logic [15:0] t_reg, t2_reg, r_reg;
    logic [1:0]  quad_reg;
    logic [1:0]  mode_reg;
    logic [63:0] acc_reg;
    logic signed [20:0] sum_reg;
    logic [31:0] ma, mb;
    logic [63:0] prod;

    assign prod = ma * mb;
    assign in_ready = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    logic [31:0] ph;
    logic [PW-1:0] pos;
    logic [15:0] tq;
    assign ph = phase_mem[v_reg];
    assign pos = ph[31-2 -: PW];
    assign tq = 16'({pos, {(17-SINE_TABLE_BITS){1'b0}}});

    // Multiplier operand select per step.
    always_comb
    begin
        ma = 32'd0;
        mb = 32'd0;
        unique case (state_reg)
            S_RATE: begin ma = 32'(attack_step_reg); mb = 32'(vel_reg); end
            S_T2:   begin ma = 32'(t_reg); mb = 32'(t_reg); end
            S_H1:   begin ma = 32'd153; mb = 32'(t2_reg); end
            S_H2, S_H3: begin ma = 32'(r_reg); mb = 32'(t2_reg); end
            S_M:    begin ma = 32'(r_reg); mb = 32'(t_reg); end
            S_G:    begin ma = acc_reg[31:0]; mb = 32'(output_gain_reg); end
            S_L:    begin
                ma = acc_reg[31:0];
                mb = (mode_reg == MODE_FULL) ? 32'(LEVEL_ONE) : 32'(level_mem[v_reg]);
            end
            default: ;
        endcase
    end

    logic [63:0] hsh;
    logic [24:0] nl;
    logic [22:0] dstep;
    logic [20:0] cval;
    assign hsh = prod >> 15;
    // One bit of headroom: level plus a large attack rate can pass 2^24.
    assign nl = 25'(level_mem[v_reg]) + 25'(rate_mem[v_reg]);
    assign dstep = (decay_step_reg == 23'd0) ? 23'd1 : decay_step_reg;
    assign cval = 21'((acc_reg + 64'h20_0000_0000) >> 38);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid <= 1'b0;
            mixed_sample <= '0;
            op_reg <= '0;
            ch_reg <= '0;
            key_reg <= '0;
            vel_reg <= '0;
            v_reg <= '0;
            t_reg <= '0;
            t2_reg <= '0;
            r_reg <= '0;
            quad_reg <= '0;
            mode_reg <= '0;
            acc_reg <= '0;
            sum_reg <= '0;
            attack_step_reg <= 23'd317;
            decay_step_reg <= 23'd190;
            output_gain_reg <= 16'd3277;
            for (int i = 0; i < VOICES; i++)
            begin
                phase_mem[i] <= 32'd0;
                inc_mem[i] <= RESET_INCREMENT;
                level_mem[i] <= LEVEL_ONE;
                mode_mem[i] <= MODE_FULL;
                fin_mem[i] <= 1'b1;
                rate_mem[i] <= 24'd0;
            end
        end
        else
        begin
            // S_DONE drives out_valid itself when a new sample replaces the old.
            if (out_valid && out_ready && state_reg != S_DONE)
                out_valid <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_ATTACK_STEP: attack_step_reg <= cfg_data;
                    REG_DECAY_STEP:  decay_step_reg <= cfg_data;
                    REG_OUTPUT_GAIN: output_gain_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                    if (in_valid && in_ready)
                    begin
                        op_reg <= op;
                        ch_reg <= channel;
                        key_reg <= key;
                        vel_reg <= velocity;
                        v_reg <= '0;
                        sum_reg <= '0;
                        if (op == OP_TICK)
                            state_reg <= S_LOAD;
                        else if ((op == OP_NOTE_ON || op == OP_NOTE_OFF)
                                 && 32'(channel) < VOICES)
                            state_reg <= S_RATE;
                    end
                S_RATE:
                begin
                    acc_reg <= prod >> 6;
                    state_reg <= S_NOTE;
                end
                S_NOTE:
                begin
                    inc_mem[ch_reg[VW-1:0]] <= key_increment(key_reg);
                    if (op_reg == OP_NOTE_ON)
                    begin
                        rate_mem[ch_reg[VW-1:0]] <= (acc_reg == 64'd0) ? 24'd1
                                                                        : acc_reg[23:0];
                        mode_mem[ch_reg[VW-1:0]] <= MODE_ATTACK;
                        if (fin_mem[ch_reg[VW-1:0]])
                            level_mem[ch_reg[VW-1:0]] <= 24'd0;
                    end
                    else
                    begin
                        mode_mem[ch_reg[VW-1:0]] <= MODE_DECAY;
                        if (fin_mem[ch_reg[VW-1:0]])
                            level_mem[ch_reg[VW-1:0]] <= LEVEL_ONE;
                    end
                    fin_mem[ch_reg[VW-1:0]] <= 1'b0;
                    state_reg <= S_IDLE;
                end
                S_LOAD:
                begin
                    quad_reg <= ph[31:30];
                    mode_reg <= mode_mem[v_reg];
                    t_reg <= ph[30] ? (16'd32768 - tq) : tq;
                    state_reg <= S_T2;
                end
                S_T2:   begin t2_reg <= hsh[15:0]; state_reg <= S_H1; end
                S_H1:   begin r_reg <= 16'(17'd2611 - hsh[16:0]); state_reg <= S_H2; end
                S_H2:   begin r_reg <= 16'(17'd21167 - hsh[16:0]); state_reg <= S_H3; end
                S_H3:   begin r_reg <= 16'(17'd51472 - hsh[16:0]); state_reg <= S_M; end
                S_M:    begin acc_reg <= hsh; state_reg <= S_G; end
                S_G:    begin acc_reg <= prod; state_reg <= S_L; end
                S_L:    begin acc_reg <= prod; state_reg <= S_ACC; end
                S_ACC:
                begin
                    if (mode_reg != MODE_WAIT)
                        sum_reg <= quad_reg[1] ? sum_reg - $signed(cval)
                                               : sum_reg + $signed(cval);
                    phase_mem[v_reg] <= ph + inc_mem[v_reg];
                    if (mode_reg == MODE_ATTACK)
                    begin
                        if (nl > 25'(LEVEL_ONE))
                        begin
                            mode_mem[v_reg] <= MODE_FULL;
                            level_mem[v_reg] <= LEVEL_ONE;
                            fin_mem[v_reg] <= 1'b1;
                        end
                        else
                            level_mem[v_reg] <= nl[23:0];
                    end
                    else if (mode_reg == MODE_DECAY)
                    begin
                        if (24'(dstep) > level_mem[v_reg])
                        begin
                            mode_mem[v_reg] <= MODE_WAIT;
                            level_mem[v_reg] <= 24'd0;
                            fin_mem[v_reg] <= 1'b1;
                        end
                        else
                            level_mem[v_reg] <= level_mem[v_reg] - 24'(dstep);
                    end
                    if (32'(v_reg) == VOICES - 1)
                        state_reg <= S_DONE;
                    else
                    begin
                        v_reg <= v_reg + VW'(1);
                        state_reg <= S_LOAD;
                    end
                end
                S_DONE:
                begin
                    // Hold the new mix until the output register is free.
                    if (!out_valid || out_ready)
                    begin
                        if (sum_reg > 21'sd32767)
                            mixed_sample <= 16'sd32767;
                        else if (sum_reg < -21'sd32768)
                            mixed_sample <= -16'sd32768;
                        else
                            mixed_sample <= sum_reg[15:0];
                        out_valid <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Not ready while a voice sweep or note update is in flight.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready) else $error("ready while busy");
    // A result only appears after the sweep's last step.
    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == S_DONE) else $error("stray result");
    // Voice index stays within the bank.
    a_vidx: assert property (@(posedge clk) disable iff (!rst_n)
        32'(v_reg) < VOICES || state_reg == S_IDLE) else $error("voice index");

endmodule

`default_nettype wire
